[hdl/psr1u_pkg.sv]
package psr1u_pkg;

    // field and register widths
    localparam int VLEN_W     = 6;
    localparam int SCALE_W    = 32;
    localparam int ELEM_IDX_W = 5;
    localparam int ELEM_W     = 32;
    localparam int ENTRY_W    = 64;
    localparam int POS_OUT_W  = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // register reset values
    localparam logic [VLEN_W-1:0]  VLEN_RESET  = 6'd1;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE         = 1'b1;

    // item opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // operand pairs of the shared multiplier
    typedef enum logic [1:0] {
        MUL_SCALE_ROW = 2'd0,
        MUL_LO        = 2'd1,
        MUL_HI        = 2'd2
    } t_mul_sel;

    // controller to datapath commands
    typedef struct packed {
        logic     wr_elem;
        logic     start_upd;
        logic     do_mag;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     do_sum;
        logic     do_rnd;
        logic     do_out;
    } t_dp_cmd;

endpackage

[hdl/psr1u_ram.sv]
module psr1u_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[hdl/psr1u_ctrl.sv]
module psr1u_ctrl import psr1u_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_opcode,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MAG    = 8'b0000_0010,
        ST_MUL_P  = 8'b0000_0100,
        ST_MUL_LO = 8'b0000_1000,
        ST_MUL_HI = 8'b0001_0000,
        ST_SUM    = 8'b0010_0000,
        ST_RND    = 8'b0100_0000,
        ST_ADD    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_acc;
    logic   out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_SCALE_ROW;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_opcode == OP_UPDATE) begin
                        o_cmd.start_upd = 1'b1;
                        n_state = ST_MAG;
                    end else begin
                        o_cmd.wr_elem = 1'b1;
                    end
                end
            end
            ST_MAG: begin
                o_cmd.do_mag = 1'b1;
                n_state = ST_MUL_P;
            end
            ST_MUL_P: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SCALE_ROW;
                n_state = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LO;
                n_state = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_HI;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.do_sum = 1'b1;
                n_state = ST_RND;
            end
            ST_RND: begin
                o_cmd.do_rnd = 1'b1;
                n_state = ST_ADD;
            end
            ST_ADD: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.do_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.do_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD && r_out_valid && !i_out_ready) |=> r_state == ST_ADD)
        else $error("finishing step left while output register busy");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_ADD)
        else $error("output valid raised outside the finishing step");

    a_update_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_opcode == OP_UPDATE) |=> r_state == ST_MAG)
        else $error("accepted update item did not start the datapath");

endmodule

[hdl/psr1u_dp.sv]
module psr1u_dp import psr1u_pkg::*; #(
    parameter int MAX_LENGTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    input  logic [ELEM_IDX_W-1:0]        i_element_index,
    input  logic signed [ELEM_W-1:0]     i_element_value,
    input  logic signed [ENTRY_W-1:0]    i_packed_value,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic signed [ENTRY_W-1:0]    o_updated_value,
    output logic [POS_OUT_W-1:0]         o_row_index,
    output logic [POS_OUT_W-1:0]         o_column_index,
    output logic                         o_saturated,
    output logic                         o_last_entry
);

    localparam int PW = $clog2(MAX_LENGTH);
    localparam int NW = $clog2(MAX_LENGTH + 1);
    localparam int LW = (NW > VLEN_W) ? NW : VLEN_W;
    localparam logic [ENTRY_W-1:0] SIGN64 = {1'b1, {(ENTRY_W-1){1'b0}}};
    localparam logic [ENTRY_W-1:0] MAX64  = {1'b0, {(ENTRY_W-1){1'b1}}};

    function automatic logic [ELEM_W-1:0] magnitude(input logic [ELEM_W-1:0] v);
        return v[ELEM_W-1] ? (~v + ELEM_W'(1)) : v;
    endfunction

    // configuration
    logic [VLEN_W-1:0]  r_vector_length;
    logic [SCALE_W-1:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_length <= VLEN_RESET;
            r_scale         <= SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VECTOR_LENGTH: r_vector_length <= i_cfg_data[VLEN_W-1:0];
                CFG_SCALE:         r_scale         <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // effective matrix order, clamped to 1..MAX_LENGTH
    logic [LW-1:0] vl_ext;
    logic [NW-1:0] n_eff;

    assign vl_ext = LW'(r_vector_length);

    always_comb begin
        if (vl_ext == '0) begin
            n_eff = NW'(1);
        end else if (vl_ext > LW'(MAX_LENGTH)) begin
            n_eff = NW'(MAX_LENGTH);
        end else begin
            n_eff = NW'(vl_ext);
        end
    end

    // packed position walk
    logic [PW-1:0] r_row_pos;
    logic [PW-1:0] r_col_pos;
    logic [PW-1:0] n_row_pos;
    logic [PW-1:0] n_col_pos;
    logic [PW-1:0] cur_row;
    logic [PW-1:0] cur_col;
    logic          pos_wrap;
    logic          last_now;

    assign pos_wrap = (NW'(r_col_pos) >= n_eff) || (r_row_pos > r_col_pos);
    assign cur_row  = pos_wrap ? '0 : r_row_pos;
    assign cur_col  = pos_wrap ? '0 : r_col_pos;
    assign last_now = (cur_row == cur_col) && ((NW'(cur_col) + NW'(1)) >= n_eff);

    always_comb begin
        if (cur_row < cur_col) begin
            n_row_pos = cur_row + PW'(1);
            n_col_pos = cur_col;
        end else if (last_now) begin
            n_row_pos = '0;
            n_col_pos = '0;
        end else begin
            n_row_pos = '0;
            n_col_pos = cur_col + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos <= '0;
            r_col_pos <= '0;
        end else if (i_cmd.start_upd) begin
            r_row_pos <= n_row_pos;
            r_col_pos <= n_col_pos;
        end
    end

    // item latched at accept
    logic [PW-1:0]      r_cur_row;
    logic [PW-1:0]      r_cur_col;
    logic               r_cur_last;
    logic [ENTRY_W-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_upd) begin
            r_cur_row  <= cur_row;
            r_cur_col  <= cur_col;
            r_cur_last <= last_now;
            r_entry    <= i_packed_value;
        end
    end

    // vector store
    logic              load_ok;
    logic [ELEM_W-1:0] x_row;
    logic [ELEM_W-1:0] x_col;

    assign load_ok = 32'(i_element_index) < 32'(MAX_LENGTH);

    psr1u_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_LENGTH)
    ) u_vec_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.wr_elem && load_ok),
        .i_waddr   (PW'(i_element_index)),
        .i_wdata   (i_element_value),
        .i_re      (i_cmd.start_upd),
        .i_raddr_a (cur_row),
        .i_raddr_b (cur_col),
        .o_rdata_a (x_row),
        .o_rdata_b (x_col)
    );

    // sign and magnitudes
    logic [ELEM_W-1:0] r_ma;
    logic [ELEM_W-1:0] r_mr;
    logic [ELEM_W-1:0] r_mc;
    logic              r_neg;

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_mag) begin
            r_ma  <= magnitude(r_scale);
            r_mr  <= magnitude(x_row);
            r_mc  <= magnitude(x_col);
            r_neg <= r_scale[SCALE_W-1] ^ x_row[ELEM_W-1] ^ x_col[ELEM_W-1];
        end
    end

    // shared 32x32 multiplier
    logic [ELEM_W-1:0]   mul_a;
    logic [ELEM_W-1:0]   mul_b;
    logic [2*ELEM_W-1:0] mul_p;
    logic [2*ELEM_W-1:0] r_p;
    logic [2*ELEM_W-1:0] r_lo;
    logic [2*ELEM_W-1:0] r_hi;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SCALE_ROW: begin
                mul_a = r_ma;
                mul_b = r_mr;
            end
            MUL_LO: begin
                mul_a = r_p[ELEM_W-1:0];
                mul_b = r_mc;
            end
            MUL_HI: begin
                mul_a = r_p[2*ELEM_W-1:ELEM_W];
                mul_b = r_mc;
            end
            default: begin
                mul_a = r_ma;
                mul_b = r_mr;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MUL_SCALE_ROW: r_p  <= mul_p;
                MUL_LO:        r_lo <= mul_p;
                MUL_HI:        r_hi <= mul_p;
                default: ;
            endcase
        end
    end

    // 96-bit magnitude, then floor to Q32.32
    logic [95:0] r_w;
    logic [79:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_sum) begin
            r_w <= {32'b0, r_lo} + {r_hi, 32'b0};
        end
        if (i_cmd.do_rnd) begin
            r_q <= r_w[95:16] + 80'(r_neg && (r_w[15:0] != 16'd0));
        end
    end

    // saturating add in offset-binary form
    logic [ENTRY_W-1:0] eu;
    logic [ENTRY_W:0]   acc;
    logic               sat;
    logic [ENTRY_W-1:0] res;

    assign eu  = r_entry ^ SIGN64;
    assign acc = r_neg ? ({1'b0, eu} - {1'b0, r_q[63:0]})
                       : ({1'b0, eu} + {1'b0, r_q[63:0]});
    assign sat = (r_q[79:64] != 16'd0) || acc[ENTRY_W];
    assign res = sat ? (r_neg ? SIGN64 : MAX64) : (acc[ENTRY_W-1:0] ^ SIGN64);

    logic [ENTRY_W-1:0]   r_out_value;
    logic [POS_OUT_W-1:0] r_out_row;
    logic [POS_OUT_W-1:0] r_out_col;
    logic                 r_out_sat;
    logic                 r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_out) begin
            r_out_value <= res;
            r_out_row   <= POS_OUT_W'(r_cur_row);
            r_out_col   <= POS_OUT_W'(r_cur_col);
            r_out_sat   <= sat;
            r_out_last  <= r_cur_last;
        end
    end

    assign o_updated_value = r_out_value;
    assign o_row_index     = r_out_row;
    assign o_column_index  = r_out_col;
    assign o_saturated     = r_out_sat;
    assign o_last_entry    = r_out_last;

    a_upper_triangle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_pos <= r_col_pos)
        else $error("packed position left the upper triangle");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start_upd && last_now) |=> (r_row_pos == '0 && r_col_pos == '0))
        else $error("position did not wrap after the final entry");

endmodule

[hdl/packed_symmetric_rank1_update.sv]
// an update item steps through magnitude, three multiplies, sum, floor and add before its result
//   is registered; no new item is taken until an update is through (one 32x32 multiplier
//   used three times per entry); one load item per cycle while no update is in progress
// the output register lets the next item enter while a result waits to be taken
// reset: synchronous active-low; clears control, position walk and registers
//   (order 1, scale 1.0); the vector store holds nothing until loaded
module packed_symmetric_rank1_update import psr1u_pkg::*; #(
    parameter int MAX_LENGTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input item channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_opcode,
    input  logic [ELEM_IDX_W-1:0]     i_element_index,
    input  logic signed [ELEM_W-1:0]  i_element_value,
    input  logic signed [ENTRY_W-1:0] i_packed_value,
    // result item channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [ENTRY_W-1:0] o_updated_value,
    output logic [POS_OUT_W-1:0]      o_row_index,
    output logic [POS_OUT_W-1:0]      o_column_index,
    output logic                      o_saturated,
    output logic                      o_last_entry,
    // register write port
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    // command bundle from the sequencer to the arithmetic path
    t_dp_cmd dp_cmd;

    // sequencer: accepts items, steps the update through
    // magnitude, three multiplies, sum, floor and saturating add
    psr1u_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    // datapath: vector store, packed position walk, shared multiplier,
    // floor to Q32.32 and saturating accumulate into the output register
    psr1u_dp #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_packed_value  (i_packed_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_updated_value (o_updated_value),
        .o_row_index     (o_row_index),
        .o_column_index  (o_column_index),
        .o_saturated     (o_saturated),
        .o_last_entry    (o_last_entry)
    );

endmodule

[tb/sv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psr1u_pkg::*;

    localparam int VEC_DEPTH    = 32;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 90;
    // load items give no result, so let the block settle before the next step
    localparam int SETTLE_CYCLES = 12;
    localparam int PRESSURE_HOLD = 300;
    localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] SAT_LO = -SAT_HI - 128'sd1;

    // one input item as the sender offers it
    typedef struct packed {
        logic                  opcode;
        logic [ELEM_IDX_W-1:0] slot;
        logic [ELEM_W-1:0]     element;
        logic [ENTRY_W-1:0]    entry;
    } t_vec_item;

    // one updated packed entry as the block returns it
    typedef struct packed {
        logic [ENTRY_W-1:0]   value;
        logic [POS_OUT_W-1:0] row;
        logic [POS_OUT_W-1:0] col;
        logic                 sat;
        logic                 last;
    } t_entry_out;

    // clock, reset and all block inputs start at known values
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_opcode    = OP_LOAD;
    logic [ELEM_IDX_W-1:0] i_element_index = '0;
    logic [ELEM_W-1:0]     i_element_value = '0;
    logic [ENTRY_W-1:0]    i_packed_value  = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_VECTOR_LENGTH;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [ENTRY_W-1:0]    o_updated_value;
    logic [POS_OUT_W-1:0]  o_row_index;
    logic [POS_OUT_W-1:0]  o_column_index;
    logic                  o_saturated;
    logic                  o_last_entry;

    // mirror of the block state, advanced in acceptance order
    logic [VLEN_W-1:0]     mirror_order = VLEN_RESET;
    logic [SCALE_W-1:0]    mirror_scale = SCALE_RESET;
    logic [ELEM_W-1:0]     mirror_vec [VEC_DEPTH];
    int unsigned           mirror_row = 0;
    int unsigned           mirror_col = 0;

    // items waiting to go out and packed entries waiting to come back
    t_vec_item             items_to_send [$];
    t_entry_out            entries_due [$];
    t_vec_item             offered;
    t_entry_out            want;
    t_entry_out            got;
    int                    queued_count   = 0;
    int                    accepted_count = 0;
    int                    results_seen   = 0;
    int                    fails          = 0;
    int                    send_gap       = 0;
    int                    hold_left      = 0;
    logic                  sending;
    logic                  taking;
    logic                  pressure_done  = 1'b0;
    logic                  steady_phase   = 1'b0;
    bit                    written_slot [VEC_DEPTH];

    packed_symmetric_rank1_update #(
        .MAX_LENGTH      (VEC_DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_packed_value  (i_packed_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_updated_value (o_updated_value),
        .o_row_index     (o_row_index),
        .o_column_index  (o_column_index),
        .o_saturated     (o_saturated),
        .o_last_entry    (o_last_entry),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // order zero acts as 1, anything past the store depth as the depth
    function automatic int unsigned effective_order(input logic [VLEN_W-1:0] order);
        if (order == 0)
            return 1;
        if (order > VEC_DEPTH)
            return VEC_DEPTH;
        return order;
    endfunction

    // entry + scale * x[row] * x[col], product floored to Q32.32, sum clamped to 64 bits
    function automatic t_entry_out next_packed_entry(input logic [ENTRY_W-1:0] entry);
        t_entry_out          res;
        int unsigned         order;
        logic signed [127:0] f_scale, f_row, f_col, f_entry, total;
        order = effective_order(mirror_order);
        // order shrunk under a half-walked matrix: restart the walk
        if (mirror_col >= order || mirror_row > mirror_col) begin
            mirror_row = 0;
            mirror_col = 0;
        end
        f_scale = $signed(mirror_scale);
        f_row   = $signed(mirror_vec[mirror_row]);
        f_col   = $signed(mirror_vec[mirror_col]);
        f_entry = $signed(entry);
        total   = ((f_scale * f_row * f_col) >>> 16) + f_entry;
        res.row = 5'(mirror_row);
        res.col = 5'(mirror_col);
        res.sat = (total > SAT_HI) || (total < SAT_LO);
        if (total > SAT_HI)
            res.value = SAT_HI[63:0];
        else if (total < SAT_LO)
            res.value = SAT_LO[63:0];
        else
            res.value = total[63:0];
        res.last = (mirror_row == mirror_col) && (mirror_col + 1 >= order);
        // packed order: rows 0..col within a column, then the next column
        if (mirror_row < mirror_col) begin
            mirror_row++;
        end else if (res.last) begin
            mirror_row = 0;
            mirror_col = 0;
        end else begin
            mirror_row = 0;
            mirror_col++;
        end
        return res;
    endfunction

    // idle length for either side: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (steady_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // q16.16 value: corners, full range, or small enough to stay clear of clamping
    function automatic logic [ELEM_W-1:0] rand_q16();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    4: return 32'h0001_0000;
                    default: return 32'hFFFF_0000;
                endcase
            end
            1, 2, 3: return $urandom;
            default: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
        endcase
    endfunction

    // q32.32 entry: corners, close to either rail, small, or full range
    function automatic logic [ENTRY_W-1:0] rand_entry();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 64'h8000_0000_0000_0000;
                    1: return 64'h7FFF_FFFF_FFFF_FFFF;
                    2: return 64'h0;
                    default: return 64'hFFFF_FFFF_FFFF_FFFF;
                endcase
            end
            1: return 64'h7FFF_FFFF_FFFF_FFFF - {24'd0, r[39:0]};
            2: return 64'h8000_0000_0000_0000 + {24'd0, r[39:0]};
            3, 4: return {{24{r[39]}}, r[39:0]};
            default: return r;
        endcase
    endfunction

    function automatic void send_item(input logic op, input logic [ELEM_IDX_W-1:0] slot,
                                      input logic [ELEM_W-1:0] element,
                                      input logic [ENTRY_W-1:0] entry);
        items_to_send.push_back('{opcode: op, slot: slot, element: element, entry: entry});
        queued_count++;
        if (op == OP_LOAD)
            written_slot[slot] = 1'b1;
    endfunction

    // register write, only ever issued while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_VECTOR_LENGTH)
            mirror_order = data[VLEN_W-1:0];
        else
            mirror_scale = data;
        @(posedge i_clk);
    endtask

    // every item taken, every entry back, and the load path settled
    task automatic wait_idle();
        while (accepted_count != queued_count || entries_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sender: holds each item until taken, predicts at acceptance, then idles a while
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
            mirror_row = 0;
            mirror_col = 0;
            mirror_order = VLEN_RESET;
            mirror_scale = SCALE_RESET;
        end else begin
            sending = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                if (offered.opcode == OP_UPDATE)
                    entries_due.push_back(next_packed_entry(offered.entry));
                else
                    mirror_vec[offered.slot] = offered.element;
                accepted_count++;
                sending = 1'b0;
                send_gap = pick_gap();
            end
            if (!sending) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (items_to_send.size() != 0) begin
                    offered = items_to_send.pop_front();
                    i_opcode        <= offered.opcode;
                    i_element_index <= offered.slot;
                    i_element_value <= offered.element;
                    i_packed_value  <= offered.entry;
                    sending = 1'b1;
                end
            end
            i_in_valid <= sending;
        end
    end

    // receiver: checks each result against the oldest prediction, stalls at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                got = {o_updated_value, o_row_index, o_column_index, o_saturated, o_last_entry};
                if (entries_due.size() == 0) begin
                    fails++;
                    $display("%0t ns: expected no result, got value %h row %0d col %0d",
                             $time, got.value, got.row, got.col);
                end else begin
                    want = entries_due.pop_front();
                    if (got !== want) begin
                        fails++;
                        $display("%0t ns: expected %h %0d %0d %b %b, got %h %0d %0d %b %b",
                                 $time,
                                 want.value, want.row, want.col, want.sat, want.last,
                                 got.value, got.row, got.col, got.sat, got.last);
                    end
                end
            end
            // one long hold-off while the sender still has plenty to offer,
            // so the block fills up and pushes back on its input
            if (!pressure_done && results_seen >= 100 && items_to_send.size() >= 40) begin
                pressure_done = 1'b1;
                hold_left = PRESSURE_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                taking = 1'b0;
            end else begin
                hold_left = pick_gap();
                taking = (hold_left == 0);
                if (hold_left > 0)
                    hold_left--;
            end
            i_out_ready <= taking;
        end
    end

    // stimulus: directed corners, then random phases with fresh settings
    initial begin
        int unsigned      order_eff;
        logic [VLEN_W-1:0] order;
        logic [SCALE_W-1:0] alpha;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: order 1, scale 1.0, plain add, clamp at the upper rail
        send_item(OP_LOAD, 5'd0, 32'h0001_0000, 64'h0);
        send_item(OP_UPDATE, 5'd31, 32'hFFFF_FFFF, 64'h0);
        send_item(OP_UPDATE, 5'd0, 32'h0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(OP_UPDATE, 5'd0, 32'h0, 64'h8000_0000_0000_0000);
        wait_idle();

        // most negative scale against extreme elements: clamping both ways
        write_reg(CFG_VECTOR_LENGTH, 32'd3);
        write_reg(CFG_SCALE, 32'h8000_0000);
        send_item(OP_LOAD, 5'd0, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_LOAD, 5'd1, 32'h7FFF_FFFF, 64'h0);
        send_item(OP_LOAD, 5'd2, 32'hFFFF_FFFF, 64'h0);
        send_item(OP_UPDATE, 5'd0, 32'h0, 64'h8000_0000_0000_0000);
        send_item(OP_UPDATE, 5'd0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_UPDATE, 5'd0, 32'h0, 64'h0);
        send_item(OP_UPDATE, 5'd0, 32'h0, 64'h7FFF_FFFF_FFFF_FFFF);
        wait_idle();

        // order zero mid-matrix: walk restarts, and a one-lsb negative
        // product must floor to minus one lsb
        write_reg(CFG_VECTOR_LENGTH, 32'd0);
        write_reg(CFG_SCALE, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 5'd0, 32'h0000_0001, 64'h0);
        send_item(OP_UPDATE, 5'd0, 32'h0, 64'h0);
        send_item(OP_UPDATE, 5'd0, 32'h0, 64'h8000_0000_0000_0000);
        wait_idle();

        // largest positive scale, mixed-sign extremes
        write_reg(CFG_VECTOR_LENGTH, 32'd2);
        write_reg(CFG_SCALE, 32'h7FFF_FFFF);
        send_item(OP_LOAD, 5'd0, 32'h7FFF_FFFF, 64'h0);
        send_item(OP_LOAD, 5'd1, 32'h8000_0000, 64'h0);
        send_item(OP_UPDATE, 5'd0, 32'h0, 64'h0);
        send_item(OP_UPDATE, 5'd0, 32'h0, 64'h0123_4567_89AB_CDEF);
        send_item(OP_UPDATE, 5'd0, 32'h0, 64'hFEDC_BA98_7654_3210);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: order = 6'd32;
                1: order = 6'd63;
                2: order = 6'd0;
                3: order = 6'd1;
                default: begin
                    case ($urandom_range(0, 9))
                        0: order = 6'd0;
                        1: order = 6'($urandom_range(33, 63));
                        2, 3, 4: order = 6'($urandom_range(1, 32));
                        default: order = 6'($urandom_range(1, 6));
                    endcase
                end
            endcase
            case (p)
                4: alpha = 32'h8000_0000;
                5: alpha = 32'h7FFF_FFFF;
                6: alpha = 32'h0;
                default: alpha = rand_q16();
            endcase
            write_reg(CFG_VECTOR_LENGTH, {26'd0, order});
            write_reg(CFG_SCALE, alpha);
            steady_phase = (p % 4 == 2);

            // no update may read an element that was never loaded
            order_eff = effective_order(order);
            for (int k = 0; k < order_eff; k++)
                if (!written_slot[k])
                    send_item(OP_LOAD, 5'(k), rand_q16(), rand_entry());

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 3) == 0)
                    send_item(OP_LOAD, 5'($urandom_range(0, 31)), rand_q16(), rand_entry());
                else
                    send_item(OP_UPDATE, 5'($urandom_range(0, 31)), $urandom, rand_entry());
            end
            wait_idle();
        end

        if (fails == 0)
            $display("packed_symmetric_rank1_update: match");
        else
            $display("packed_symmetric_rank1_update: mismatch");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #2_000_000;
        $display("packed_symmetric_rank1_update: mismatch");
        $finish;
    end

endmodule
